FILE: src/bba_pkg.sv
// Shared codes and controller/datapath handshake types for the block allocator.
package bba_pkg;

   localparam int OP_W     = 1;
   localparam int COUNT_W  = 7;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 11;

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FREED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

   localparam int CFG_RESET = 1024;

   typedef struct packed {
      logic load_req;
      logic load_cfg;
      logic clr_step;
      logic rd_idx;
      logic emit_bad;
      logic emit_nospace;
      logic free_commit;
      logic alloc_take;
      logic ptr_step;
      logic adv_start;
      logic ptr_commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_free;
      logic clr_last;
      logic count_bad;
      logic no_space;
      logic idx_bad;
      logic map_bit;
      logic take_last;
      logic adv_done;
   } dp_status_type;

endpackage

FILE: src/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/bba_datapath.sv
// Allocator datapath: bitmap RAM, next-fit pointer, free count and result registers.
module bba_datapath #(
   parameter int NUM_BLOCKS  = 1024,
   parameter int MAX_REQUEST = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bba_pkg::ctl_cmd_type                   cmd,
   output bba_pkg::dp_status_type                 st,
   input  logic [bba_pkg::OP_W-1:0]               req_op,
   input  logic [bba_pkg::COUNT_W-1:0]            req_count,
   input  logic [bba_pkg::INDEX_W-1:0]            req_block_index,
   input  logic [bba_pkg::CFG_W-1:0]              csr_wdata,
   output logic                                   rsp_valid,
   output logic [bba_pkg::INDEX_W-1:0]            rsp_block_number,
   output logic [bba_pkg::STATUS_W-1:0]           rsp_status,
   output logic                                   rsp_last
);
   import bba_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int N_RESET = (CFG_RESET > NUM_BLOCKS) ? NUM_BLOCKS : CFG_RESET;

   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       free_ff, free_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic [COUNT_W-1:0]  k_ff, k_in;
   logic [OP_W-1:0]     op_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_blk_ff, rsp_blk_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [31:0]   cfg_wide;
   logic [CW-1:0] cfg_n;
   logic [CW-1:0] scan_plus;
   logic [AW-1:0] scan_next;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   logic [0:0]    ram_rdata;

   // Clamp the written block count to 1..NUM_BLOCKS.
   always_comb begin
      cfg_wide = 32'(csr_wdata);
      if (cfg_wide == 32'd0) begin
         cfg_n = CW'(1);
      end else if (cfg_wide > 32'(NUM_BLOCKS)) begin
         cfg_n = CW'(NUM_BLOCKS);
      end else begin
         cfg_n = CW'(cfg_wide);
      end
   end

   assign scan_plus = CW'(scan_ff) + CW'(1);
   assign scan_next = (scan_plus >= n_ff) ? '0 : AW'(scan_plus);

   always_comb begin
      ram_we    = cmd.clr_step | cmd.free_commit | cmd.alloc_take;
      ram_waddr = scan_ff;
      if (cmd.clr_step) begin
         ram_waddr = clr_ff;
      end else if (cmd.free_commit) begin
         ram_waddr = AW'(idx_ff);
      end
      ram_raddr = cmd.rd_idx ? AW'(idx_ff) : scan_ff;
   end

   bba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (cmd.alloc_take),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      st.req_free  = (req_op == OP_FREE);
      st.clr_last  = (clr_ff == AW'(NUM_BLOCKS - 1));
      st.count_bad = (count_ff == '0) || (32'(count_ff) > 32'(MAX_REQUEST));
      st.no_space  = (32'(count_ff) > 32'(free_ff));
      st.idx_bad   = (32'(idx_ff) >= 32'(n_ff));
      st.map_bit   = ram_rdata[0];
      st.take_last = ((k_ff + COUNT_W'(1)) == count_ff);
      st.adv_done  = (steps_ff == n_ff);
   end

   always_comb begin
      n_in         = n_ff;
      free_in      = free_ff;
      ptr_in       = ptr_ff;
      scan_in      = scan_ff;
      clr_in       = clr_ff;
      steps_in     = steps_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_blk_in   = rsp_blk_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load_cfg) begin
         n_in    = cfg_n;
         free_in = cfg_n;
         ptr_in  = '0;
         clr_in  = '0;
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.load_req) begin
         scan_in = ptr_ff;
         k_in    = '0;
      end
      if (cmd.emit_bad) begin
         rsp_valid_in = 1'b1;
         rsp_blk_in   = (op_ff == OP_FREE) ? idx_ff : '0;
         rsp_st_in    = ST_BAD;
         rsp_last_in  = 1'b1;
      end
      if (cmd.emit_nospace) begin
         rsp_valid_in = 1'b1;
         rsp_blk_in   = '0;
         rsp_st_in    = ST_NOSPACE;
         rsp_last_in  = 1'b1;
      end
      if (cmd.free_commit) begin
         free_in      = free_ff + CW'(1);
         rsp_valid_in = 1'b1;
         rsp_blk_in   = idx_ff;
         rsp_st_in    = ST_FREED;
         rsp_last_in  = 1'b1;
      end
      if (cmd.alloc_take) begin
         free_in      = free_ff - CW'(1);
         k_in         = k_ff + COUNT_W'(1);
         scan_in      = scan_next;
         rsp_valid_in = 1'b1;
         rsp_blk_in   = INDEX_W'(scan_ff);
         rsp_st_in    = ST_ALLOC;
         rsp_last_in  = st.take_last;
      end
      if (cmd.ptr_step) begin
         scan_in  = scan_next;
         steps_in = steps_ff + CW'(1);
      end
      if (cmd.adv_start) begin
         steps_in = '0;
      end
      if (cmd.ptr_commit) begin
         ptr_in = scan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= CW'(N_RESET);
         free_ff      <= CW'(N_RESET);
         ptr_ff       <= '0;
         scan_ff      <= '0;
         clr_ff       <= '0;
         steps_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         free_ff      <= free_in;
         ptr_ff       <= ptr_in;
         scan_ff      <= scan_in;
         clr_ff       <= clr_in;
         steps_ff     <= steps_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         count_ff <= req_count;
         idx_ff   <= req_block_index;
      end
      rsp_blk_ff  <= rsp_blk_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_blk_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_last         = rsp_last_ff;
endmodule

FILE: src/bba_controller.sv
// Allocator control state machine: clearing pass, free, allocate scan and pointer advance.
module bba_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   csr_valid,
   input  bba_pkg::dp_status_type st,
   output bba_pkg::ctl_cmd_type   cmd,
   output logic                   busy,
   output logic                   csr_ready
);
   import bba_pkg::*;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_FREE_RD   = 4'd2;
   localparam logic [3:0] S_FREE_CHK  = 4'd3;
   localparam logic [3:0] S_ALLOC_CHK = 4'd4;
   localparam logic [3:0] S_SCAN_RD   = 4'd5;
   localparam logic [3:0] S_SCAN_CHK  = 4'd6;
   localparam logic [3:0] S_ADV_RD    = 4'd7;
   localparam logic [3:0] S_ADV_CHK   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (csr_valid) begin
               cmd.load_cfg = 1'b1;
               state_in     = S_CLEAR;
            end else if (start) begin
               cmd.load_req = 1'b1;
               state_in     = st.req_free ? S_FREE_RD : S_ALLOC_CHK;
            end
         end
         S_FREE_RD: begin
            cmd.rd_idx = 1'b1;
            state_in   = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (st.idx_bad || !st.map_bit) begin
               cmd.emit_bad = 1'b1;
            end else begin
               cmd.free_commit = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_ALLOC_CHK: begin
            priority if (st.count_bad) begin
               cmd.emit_bad = 1'b1;
               state_in     = S_IDLE;
            end else if (st.no_space) begin
               cmd.emit_nospace = 1'b1;
               state_in         = S_IDLE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (!st.map_bit) begin
               cmd.alloc_take = 1'b1;
               if (st.take_last) begin
                  cmd.adv_start = 1'b1;
                  state_in      = S_ADV_RD;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else begin
               cmd.ptr_step = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_ADV_RD: begin
            if (st.adv_done) begin
               cmd.ptr_commit = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_ADV_CHK;
            end
         end
         S_ADV_CHK: begin
            if (st.map_bit) begin
               cmd.ptr_step = 1'b1;
               state_in     = S_ADV_RD;
            end else begin
               cmd.ptr_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE) | csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
endmodule

FILE: src/bitmap_block_allocator_next_fit.sv
// A free gives its single result after a RAM read and a check; a refused allocate gives
// its result from the count and space check. An allocate visits bitmap positions from the
// pointer with one RAM read and one decision each, then skips used positions the same
// way while advancing the pointer. The controller takes one transaction at a time.
// Reset (and every csr write) clears all NUM_BLOCKS bitmap positions with busy high.
// Results are strobed on rsp_valid for one cycle; the receiver cannot stall.
module bitmap_block_allocator_next_fit #(
   parameter int NUM_BLOCKS  = 1024,
   parameter int MAX_REQUEST = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request transaction
   input  logic                                start,
   output logic                                busy,
   input  logic [bba_pkg::OP_W-1:0]            req_op,
   input  logic [bba_pkg::COUNT_W-1:0]         req_count,
   input  logic [bba_pkg::INDEX_W-1:0]         req_block_index,
   // result strobe
   output logic                                rsp_valid,
   output logic [bba_pkg::INDEX_W-1:0]         rsp_block_number,
   output logic [bba_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_last,
   // block count register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bba_pkg::CFG_W-1:0]           csr_wdata
);
   import bba_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type st;

   // Sequence clearing and each transaction: dispatch, free check or scan, pointer park.
   bba_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .csr_ready (csr_ready)
   );

   // Hold the bitmap, pointer, free count and the result register.
   bba_datapath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .MAX_REQUEST (MAX_REQUEST)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_op           (req_op),
      .req_count        (req_count),
      .req_block_index  (req_block_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the next-fit bitmap block allocator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bba_pkg::*;

   localparam int NUM_BLOCKS   = 1024;
   localparam int MAX_REQUEST  = 64;
   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 5;
   localparam int MAX_GAP      = 18;
   // Pointer advance may walk the whole map, one RAM read and one decision per position,
   // after the last result of an allocate, so give the block that long to go quiet.
   localparam int SETTLE_CYCLES = 2 * NUM_BLOCKS + 16;
   // Worst case: full scan and advance per item, ~350 items; allow a few times that.
   localparam int RUN_LIMIT_NS = 60_000_000;

   // One result transaction as the block strobes it.
   typedef struct packed {
      logic [INDEX_W-1:0]  block_number;
      logic [STATUS_W-1:0] status;
      logic                last;
   } alloc_result_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op          = OP_ALLOC;
   logic [COUNT_W-1:0]  req_count       = '0;
   logic [INDEX_W-1:0]  req_block_index = '0;
   logic                rsp_valid;
   logic [INDEX_W-1:0]  rsp_block_number;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;
   logic                csr_valid       = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_wdata       = '0;

   // Shadow copy of the allocator state, updated as each transaction is accepted.
   bit                  block_used [NUM_BLOCKS];
   int unsigned         alloc_ptr;
   int unsigned         free_left;
   int unsigned         blocks_cfg;

   alloc_result_type    expected_blocks [$];
   int                  error_count = 0;
   int                  burst_left  = 0;

   bitmap_block_allocator_next_fit #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .MAX_REQUEST (MAX_REQUEST)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_count        (req_count),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------------
   // Allocator prediction
   // ---------------------------------------------------------------------------

   // Effective block count: zero acts as one, anything past the map size is clamped.
   function automatic int unsigned managed_blocks();
      int unsigned v;
      v = blocks_cfg;
      if (v == 0) v = 1;
      if (v > NUM_BLOCKS) v = NUM_BLOCKS;
      return v;
   endfunction

   // Clear the map and rewind the pointer, as reset and every register write do.
   function automatic void reformat_map();
      foreach (block_used[i]) block_used[i] = 1'b0;
      alloc_ptr = 0;
      free_left = managed_blocks();
   endfunction

   function automatic int unsigned wrap_next(int unsigned p, int unsigned n);
      return (p + 1 >= n) ? 0 : p + 1;
   endfunction

   // Compute the results one accepted transaction causes and queue them in order.
   task automatic predict_request(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] cnt,
                                  input logic [INDEX_W-1:0] idx);
      int unsigned n;
      int unsigned p;
      int unsigned k;
      int unsigned steps;
      n = managed_blocks();
      if (alloc_ptr >= n) alloc_ptr = 0;
      if (op == OP_FREE) begin
         // Out-of-range index and double free both come back as bad, map untouched.
         if (idx >= n || !block_used[idx]) begin
            expected_blocks.push_back('{idx, ST_BAD, 1'b1});
         end else begin
            block_used[idx] = 1'b0;
            free_left++;
            expected_blocks.push_back('{idx, ST_FREED, 1'b1});
         end
      end else if (cnt == 0 || cnt > MAX_REQUEST) begin
         expected_blocks.push_back('{'0, ST_BAD, 1'b1});
      end else if (cnt > free_left) begin
         expected_blocks.push_back('{'0, ST_NOSPACE, 1'b1});
      end else begin
         // Next-fit scan from the pointer, taking free blocks until the count is met.
         p = alloc_ptr;
         k = 0;
         for (steps = 0; steps < n && k < cnt; steps++) begin
            if (!block_used[p]) begin
               block_used[p] = 1'b1;
               free_left--;
               expected_blocks.push_back('{INDEX_W'(p), ST_ALLOC, (k + 1 == cnt)});
               k++;
            end
            p = wrap_next(p, n);
         end
         // Skip past used blocks; a full map leaves the pointer where it started.
         for (steps = 0; steps < n && block_used[p]; steps++) p = wrap_next(p, n);
         alloc_ptr = p;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result checking: every strobe is matched against the oldest expectation.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected result: block_number %0d status %0d last %0d",
                   rsp_block_number, rsp_status, rsp_last);
            error_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_block_number !== want.block_number) begin
               $error("block_number mismatch: expected %0d, actual %0d",
                      want.block_number, rsp_block_number);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers. Most tasks enter after a rising edge, and every task drives on falling edges.
   // ---------------------------------------------------------------------------

   // Send one request transaction after a random gap; return at the accepting edge
   // with start still high, so the next call either holds it or drops it once.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] cnt,
                               input logic [INDEX_W-1:0] idx);
      int unsigned gap;
      @(negedge clock);
      if (burst_left > 0) begin
         // Back-to-back stretch: hold start high across transactions.
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_op          <= op;
      req_count       <= cnt;
      req_block_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_request(op, cnt, idx);
   endtask

   // Drop start, drain every expected result, then let the pointer advance finish.
   task automatic settle_block();
      @(negedge clock);
      start <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the block count register; the block re-formats its map on the write.
   task automatic write_block_count(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      blocks_cfg = value;
      reformat_map();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Find a block in the wanted state, scanning from a given position; -1 if none.
   function automatic int find_block(input int unsigned from, input bit want_used);
      int unsigned n;
      int unsigned p;
      n = managed_blocks();
      p = from % n;
      for (int unsigned i = 0; i < n; i++) begin
         if (block_used[p] == want_used) return p;
         p = wrap_next(p, n);
      end
      return -1;
   endfunction

   // Mostly well-formed traffic that keeps the map around half full, with noise:
   // bad counts, oversized requests, out-of-range and double frees.
   task automatic random_request();
      int unsigned n;
      int unsigned lim;
      int          found;
      logic [COUNT_W-1:0] junk_count;
      logic [INDEX_W-1:0] junk_index;
      n          = managed_blocks();
      junk_count = COUNT_W'($urandom_range(0, 127));
      junk_index = INDEX_W'($urandom_range(0, NUM_BLOCKS - 1));
      if ($urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 3))
            0: send_request(OP_ALLOC, $urandom_range(0, 1) ? COUNT_W'(0)
                            : COUNT_W'($urandom_range(MAX_REQUEST + 1, 127)), junk_index);
            1: begin
               if (free_left < MAX_REQUEST)
                  send_request(OP_ALLOC, COUNT_W'($urandom_range(free_left + 1, MAX_REQUEST)),
                               junk_index);
               else
                  send_request(OP_ALLOC, COUNT_W'(0), junk_index);
            end
            2: begin
               if (n < NUM_BLOCKS)
                  send_request(OP_FREE, junk_count,
                               INDEX_W'($urandom_range(n, NUM_BLOCKS - 1)));
               else
                  send_request(OP_FREE, junk_count, INDEX_W'(find_block(0, 1'b0) & 10'h3FF));
            end
            default: begin
               found = find_block($urandom_range(0, n - 1), 1'b0);
               send_request(OP_FREE, junk_count, (found < 0) ? junk_index : INDEX_W'(found));
            end
         endcase
      end else begin
         // Allocate with a probability that falls as the map fills.
         if (free_left > 0 && (free_left == n || $urandom_range(0, 99) < free_left * 100 / n))
         begin
            lim = (free_left < MAX_REQUEST) ? free_left : MAX_REQUEST;
            if ($urandom_range(0, 3) != 0 && lim > 8) lim = 8;
            send_request(OP_ALLOC, COUNT_W'($urandom_range(1, lim)), junk_index);
         end else begin
            found = find_block($urandom_range(0, n - 1), 1'b1);
            send_request(OP_FREE, junk_count, INDEX_W'(found));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes, every status and the pointer corner cases.
   task automatic test_directed_cases();
      // Reset count of 1024: block 0, then a maximum-size run of 64.
      send_request(OP_ALLOC, 7'd1, 10'd1023);
      send_request(OP_ALLOC, 7'd64, 10'd0);
      send_request(OP_ALLOC, 7'd0, 10'd0);
      send_request(OP_ALLOC, 7'd65, 10'd512);
      send_request(OP_ALLOC, 7'd127, 10'd1023);
      send_request(OP_FREE, 7'd0, 10'd0);
      // Double free and a free of a never-used block are both refused.
      send_request(OP_FREE, 7'd127, 10'd0);
      send_request(OP_FREE, 7'd0, 10'd1023);
      // Freed block 0 sits behind the pointer; next-fit must not go back for it.
      send_request(OP_ALLOC, 7'd2, 10'd0);

      // A written zero acts as a single block.
      settle_block();
      write_block_count(11'd0);
      send_request(OP_ALLOC, 7'd1, 10'd0);
      send_request(OP_ALLOC, 7'd1, 10'd0);
      send_request(OP_FREE, 7'd0, 10'd1);
      send_request(OP_FREE, 7'd0, 10'd0);

      // Sixteen blocks: fill the map so the pointer makes a full turn and stops.
      settle_block();
      write_block_count(11'd16);
      send_request(OP_ALLOC, 7'd16, 10'd0);
      send_request(OP_ALLOC, 7'd1, 10'd0);
      send_request(OP_FREE, 7'd0, 10'd9);
      send_request(OP_FREE, 7'd0, 10'd5);
      send_request(OP_ALLOC, 7'd2, 10'd0);
      send_request(OP_FREE, 7'd0, 10'd15);
      send_request(OP_FREE, 7'd0, 10'd16);

      // All-ones count clamps to the full map.
      settle_block();
      write_block_count(11'd2047);
      send_request(OP_ALLOC, 7'd64, 10'd0);

      settle_block();
      write_block_count(11'd1);
      send_request(OP_ALLOC, 7'd1, 10'd0);
      send_request(OP_FREE, 7'd0, 10'd0);
   endtask

   // One random traffic phase at a given block count.
   task automatic test_random_traffic(input logic [CFG_W-1:0] count_value, input int items);
      settle_block();
      write_block_count(count_value);
      repeat (items) random_request();
   endtask

   initial begin
      blocks_cfg = CFG_RESET;
      reformat_map();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(CFG_W'($urandom_range(2, 8)), 50);
      test_random_traffic(CFG_W'($urandom_range(9, 64)), 100);
      test_random_traffic(CFG_W'($urandom_range(65, 400)), 80);
      test_random_traffic(CFG_W'(NUM_BLOCKS), 50);
      test_random_traffic(CFG_W'($urandom_range(NUM_BLOCKS + 1, 2046)), 40);

      settle_block();
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   initial begin
      #RUN_LIMIT_NS;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

FILE: bitmap_block_allocator_next_fit.f
src/bba_pkg.sv
src/bba_ram.sv
src/bba_datapath.sv
src/bba_controller.sv
src/bitmap_block_allocator_next_fit.sv
tb/sv/tb_top.sv
